>>> design/positive_float32_adder_macros.svh
// assertion macros shared by the checker files
// no dependencies
`ifndef POSITIVE_FLOAT32_ADDER_MACROS_SVH
`define POSITIVE_FLOAT32_ADDER_MACROS_SVH

// check that a condition implies a consequence in the same cycle
`define PFA_ASSERT_SAME(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error(msg);

// check that a condition implies a consequence in the next cycle
`define PFA_ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pfa_pkg.sv
// package for the positive float32 adder: constants and field types
// no dependencies
package pfa_pkg;
    localparam int WordW = 32;
    localparam int ExpW  = 8;
    localparam int FracW = 23;
    localparam int SigW  = FracW + 1;

    localparam logic [WordW-1:0] InfPattern = 32'h7F80_0000;
    localparam logic [ExpW-1:0]  ExpMax     = 8'hFF;

    typedef logic [WordW-1:0] word_t;
    typedef logic [ExpW-1:0]  exp_t;
    typedef logic [SigW-1:0]  sig_t;

    // result of the combinational add
    typedef struct packed {
        word_t sum_word;
        logic  overflowed;
    } result_t;
endpackage

>>> design/pfa_datapath.sv
// combinational magnitude add of two single-precision patterns
// depends on pfa_pkg
module pfa_datapath import pfa_pkg::*; (
    input  word_t   addend_a,
    input  word_t   addend_b,
    output result_t result
);
    exp_t              ea, eb, e_big, diff;
    sig_t              fa, fb, f_big, f_small, f_shift;
    logic [SigW:0]     sum;
    logic [ExpW:0]     e_fin;
    logic              a_zero, b_zero;

    always_comb begin
        a_zero  = (addend_a[WordW-2:0] == '0);
        b_zero  = (addend_b[WordW-2:0] == '0);
        ea      = addend_a[WordW-2:FracW];
        eb      = addend_b[WordW-2:FracW];
        fa      = {1'b1, addend_a[FracW-1:0]};
        fb      = {1'b1, addend_b[FracW-1:0]};
        // align the smaller operand, truncating
        if (ea >= eb) begin
            e_big   = ea;
            diff    = ea - eb;
            f_big   = fa;
            f_small = fb;
        end else begin
            e_big   = eb;
            diff    = eb - ea;
            f_big   = fb;
            f_small = fa;
        end
        f_shift = (diff >= ExpW'(SigW)) ? '0 : (f_small >> diff);
        sum     = {1'b0, f_big} + {1'b0, f_shift};
        // renormalize on carry out
        e_fin   = {1'b0, e_big} + {{ExpW{1'b0}}, sum[SigW]};
        if (sum[SigW]) begin
            sum = sum >> 1;
        end
        // select special cases
        if (a_zero) begin
            result = '{sum_word: {1'b0, addend_b[WordW-2:0]}, overflowed: 1'b0};
        end else if (b_zero) begin
            result = '{sum_word: {1'b0, addend_a[WordW-2:0]}, overflowed: 1'b0};
        end else if (e_fin >= {1'b0, ExpMax}) begin
            result = '{sum_word: InfPattern, overflowed: 1'b1};
        end else begin
            result = '{sum_word: {1'b0, e_fin[ExpW-1:0], sum[FracW-1:0]}, overflowed: 1'b0};
        end
    end
endmodule

>>> design/positive_float32_adder.sv
// channel | ports                      | transfer when
// input   | s_valid s_ready s_addend_* | s_valid && s_ready
// result  | m_valid m_ready m_sum_word m_overflowed | m_valid && m_ready
// one item per cycle while the result stage is empty or m_ready is high
// an item passes the input register, then the result register, around one add
// aresetn (synchronous, active low) clears both valid bits
// a stalled result stage holds and back-pressures the input stage
// top level of the positive float32 adder; depends on pfa_pkg, pfa_datapath
module positive_float32_adder import pfa_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  word_t s_addend_a,
    input  word_t s_addend_b,
    output logic  m_valid,
    input  logic  m_ready,
    output word_t m_sum_word,
    output logic  m_overflowed
);
    logic    in_vld_reg;
    word_t   a_reg, b_reg;
    result_t res_reg;
    result_t res_next;
    logic    out_vld_reg;
    logic    out_adv, in_adv;

    assign out_adv = !out_vld_reg || m_ready;
    assign in_adv  = !in_vld_reg || out_adv;
    assign s_ready = in_adv;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_adv) begin
            in_vld_reg <= s_valid;
        end
        if (in_adv && s_valid) begin
            a_reg <= s_addend_a;
            b_reg <= s_addend_b;
        end
    end

    pfa_datapath u_dp (.addend_a(a_reg), .addend_b(b_reg), .result(res_next));

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_adv) begin
            out_vld_reg <= in_vld_reg;
        end
        if (out_adv && in_vld_reg) begin
            res_reg <= res_next;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_sum_word   = res_reg.sum_word;
    assign m_overflowed = res_reg.overflowed;
endmodule

>>> design/pfa_checker.sv
// port-level checker for the positive float32 adder, bound to the top level
// depends on pfa_pkg and positive_float32_adder_macros.svh
`include "positive_float32_adder_macros.svh"
module pfa_checker import pfa_pkg::*; (
    input logic  aclk,
    input logic  aresetn,
    input logic  s_ready,
    input logic  m_valid,
    input logic  m_ready,
    input word_t m_sum_word,
    input logic  m_overflowed
);
    logic is_inf;
    logic stalled;

    // helper terms for the properties
    assign is_inf  = (m_sum_word == InfPattern);
    assign stalled = m_valid && !m_ready;

    `PFA_ASSERT_SAME(a_sign_zero, aclk, aresetn, m_valid, !m_sum_word[WordW-1], "sign set")
    `PFA_ASSERT_SAME(a_ovf_inf, aclk, aresetn, m_valid && m_overflowed, is_inf, "ovf without inf")
    `PFA_ASSERT_NEXT(a_hold, aclk, aresetn, stalled, m_valid && $stable(m_sum_word), "result dropped")
    `PFA_ASSERT_SAME(a_ready, aclk, aresetn, !m_valid, s_ready, "stalled while empty")
endmodule

bind positive_float32_adder pfa_checker u_pfa_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_sum_word(m_sum_word),
    .m_overflowed(m_overflowed)
);
